// ----- hw/rtl/qva_pkg.sv -----
// Shared types, codes and reset constants for the quorum vote arbiter.
`timescale 1ns / 1ps

package qva_pkg;

  localparam int unsigned TimeWidthDef = 32;
  localparam int unsigned TimeFieldW   = 32;
  localparam int unsigned HostWidth    = 32;
  localparam int unsigned DurWidth     = 16;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 32;

  localparam logic [HostWidth-1:0] NoHost = {HostWidth{1'b1}};

  localparam logic ReqBeacon = 1'b0;
  localparam logic ReqPoll   = 1'b1;

  localparam logic [HostWidth-1:0] MyHostRst    = '0;
  localparam logic [DurWidth-1:0]  BigTimeRst   = 16'd75;
  localparam logic [DurWidth-1:0]  SmallTimeRst = 16'd60;
  localparam logic [DurWidth-1:0]  MaxSkewRst   = 16'd10;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StSkew      = 2'd1,
    StNotMember = 2'd2,
    StNotAuth   = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegMyHost    = 2'd0,
    RegBigTime   = 2'd1,
    RegSmallTime = 2'd2,
    RegMaxSkew   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [HostWidth-1:0] my_host;
    logic [DurWidth-1:0]  big_time;
    logic [DurWidth-1:0]  small_time;
    logic [DurWidth-1:0]  max_skew;
  } cfg_t;

  typedef struct packed {
    logic                  req_type;
    logic [TimeFieldW-1:0] now;
    logic [HostWidth-1:0]  other_host;
    logic                  claims_sync;
    logic [TimeFieldW-1:0] claim_start;
    logic                  is_remote;
    logic                  auth_ok;
    logic                  is_member;
  } item_t;

  typedef struct packed {
    status_e               status;
    logic [TimeFieldW-1:0] vote_time;
    logic                  should_run;
    logic                  sync_known;
    logic [HostWidth-1:0]  sync_host;
  } result_t;

endpackage

// ----- hw/rtl/qva_cfg_regs.sv -----
// Configuration registers of the quorum vote arbiter.
`timescale 1ns / 1ps

module qva_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [qva_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [qva_pkg::CfgDataW-1:0] cfg_wdata_i,
  output qva_pkg::cfg_t                cfg_o
);

  qva_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.my_host    <= qva_pkg::MyHostRst;
      cfg_q.big_time   <= qva_pkg::BigTimeRst;
      cfg_q.small_time <= qva_pkg::SmallTimeRst;
      cfg_q.max_skew   <= qva_pkg::MaxSkewRst;
    end else if (cfg_we_i) begin
      case (qva_pkg::cfg_reg_e'(cfg_idx_i))
        qva_pkg::RegMyHost: begin
          cfg_q.my_host <= qva_pkg::HostWidth'(cfg_wdata_i);
        end
        qva_pkg::RegBigTime: begin
          cfg_q.big_time <= cfg_wdata_i[qva_pkg::DurWidth-1:0];
        end
        qva_pkg::RegSmallTime: begin
          cfg_q.small_time <= cfg_wdata_i[qva_pkg::DurWidth-1:0];
        end
        qva_pkg::RegMaxSkew: begin
          cfg_q.max_skew <= cfg_wdata_i[qva_pkg::DurWidth-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/qva_vote_core.sv -----
// Vote state and single-pass beacon/poll decision logic.
`timescale 1ns / 1ps

module qva_vote_core #(
  parameter int unsigned TimeWidth = qva_pkg::TimeWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  qva_pkg::cfg_t   cfg_i,
  input  qva_pkg::item_t  item_i,
  input  logic            fire_i,
  output qva_pkg::result_t res_o
);

  typedef logic [TimeWidth-1:0]          tm_t;
  typedef logic [qva_pkg::HostWidth-1:0] host_t;

  // a > b by more than d, no wrap
  function automatic logic exceeds(tm_t a, tm_t b, logic [qva_pkg::DurWidth-1:0] d);
    return (a > b) && ((a - b) > TimeWidth'(d));
  endfunction

  tm_t   yes_time_q, yes_time_d;
  host_t yes_host_q, yes_host_d;
  tm_t   yes_claim_q, yes_claim_d;
  logic  yes_was_sync_q, yes_was_sync_d;
  tm_t   low_time_q, low_time_d;
  host_t low_host_q, low_host_d;
  tm_t   seen_time_q, seen_time_d;
  host_t seen_host_q, seen_host_d;

  tm_t              now_t, start_t, vote_t;
  host_t            other;
  logic             remote, sync, refuse, known;
  qva_pkg::status_e status;

  always_comb begin
    yes_time_d     = yes_time_q;
    yes_host_d     = yes_host_q;
    yes_claim_d    = yes_claim_q;
    yes_was_sync_d = yes_was_sync_q;
    low_time_d     = low_time_q;
    low_host_d     = low_host_q;
    seen_time_d    = seen_time_q;
    seen_host_d    = seen_host_q;
    now_t   = tm_t'(item_i.now);
    start_t = tm_t'(item_i.claim_start);
    remote  = item_i.is_remote;
    sync    = item_i.claims_sync;
    other   = remote ? item_i.other_host : cfg_i.my_host;
    status  = qva_pkg::StOk;
    vote_t  = '0;
    refuse  = 1'b0;

    if (item_i.req_type == qva_pkg::ReqBeacon) begin
      if (remote && !item_i.auth_ok) begin
        status = qva_pkg::StNotAuth;
      end else if (exceeds(now_t, start_t, cfg_i.max_skew)) begin
        status = qva_pkg::StSkew;
      end else if (exceeds(start_t, now_t, cfg_i.max_skew) || (yes_time_q > now_t)) begin
        // sender far ahead or our vote is in the future: start over
        status         = qva_pkg::StSkew;
        yes_time_d     = now_t;
        yes_host_d     = qva_pkg::NoHost;
        yes_claim_d    = '0;
        yes_was_sync_d = 1'b0;
        low_time_d     = '0;
        low_host_d     = qva_pkg::NoHost;
        seen_time_d    = '0;
        seen_host_d    = '0;
      end else if (exceeds(yes_time_q, start_t, cfg_i.max_skew)) begin
        status = qva_pkg::StSkew;
      end else if (remote && !item_i.is_member) begin
        status = qva_pkg::StNotMember;
      end else begin
        if ((other <= low_host_d) || exceeds(now_t, low_time_d, cfg_i.big_time)) begin
          low_time_d = now_t;
          low_host_d = other;
        end
        if ((cfg_i.my_host <= low_host_d) || exceeds(now_t, low_time_d, cfg_i.big_time)) begin
          low_time_d = now_t;
          low_host_d = cfg_i.my_host;
        end
        if (sync && (seen_time_d <= now_t)) begin
          seen_host_d = other;
          seen_time_d = now_t;
        end
        if (exceeds(now_t, seen_time_d, cfg_i.big_time)) begin
          seen_host_d = '0;
          seen_time_d = '0;
        end
        refuse = !sync &&
                 (((low_host_d != other) && !exceeds(now_t, low_time_d, cfg_i.big_time)) ||
                  ((seen_host_d != '0) && (seen_host_d != other)));
        if (!refuse && (yes_time_q <= now_t) && (yes_claim_q <= start_t) &&
            (exceeds(now_t, yes_time_q, cfg_i.big_time) || (other == yes_host_q))) begin
          vote_t         = now_t;
          yes_time_d     = now_t;
          yes_claim_d    = start_t;
          yes_host_d     = other;
          yes_was_sync_d = sync;
        end
      end
    end

    // status fields look at the state after this item
    known = yes_was_sync_d && !exceeds(now_t, yes_claim_d, cfg_i.small_time);
    res_o.status     = status;
    res_o.vote_time  = qva_pkg::TimeFieldW'(vote_t);
    res_o.should_run = exceeds(now_t, yes_time_d, cfg_i.big_time) ||
                       !((yes_was_sync_d && (yes_host_d != cfg_i.my_host)) ||
                         (yes_host_d < cfg_i.my_host));
    res_o.sync_known = known;
    res_o.sync_host  = known ? yes_host_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yes_time_q     <= '0;
      yes_host_q     <= qva_pkg::NoHost;
      yes_claim_q    <= '0;
      yes_was_sync_q <= 1'b0;
      low_time_q     <= '0;
      low_host_q     <= qva_pkg::NoHost;
      seen_time_q    <= '0;
      seen_host_q    <= '0;
    end else if (fire_i) begin
      yes_time_q     <= yes_time_d;
      yes_host_q     <= yes_host_d;
      yes_claim_q    <= yes_claim_d;
      yes_was_sync_q <= yes_was_sync_d;
      low_time_q     <= low_time_d;
      low_host_q     <= low_host_d;
      seen_time_q    <= seen_time_d;
      seen_host_q    <= seen_host_d;
    end
  end

endmodule

// ----- hw/rtl/quorum_vote_arbiter.sv -----
// An accepted item is held in the input register; its result then moves into the result register.
// Throughput: one item per cycle unless the result register stalls; the decision and
// state update share one stage between the input register and the result register.
// A full result register under stall holds the input register, which then stalls.
// Reset: vote state and config registers return to their defaults, both stages empty.
`timescale 1ns / 1ps

module quorum_vote_arbiter #(
  parameter int unsigned TimeWidth = qva_pkg::TimeWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  qva_pkg::item_t               in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output qva_pkg::result_t             out_data_o,
  input  logic                         cfg_we_i,
  input  logic [qva_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [qva_pkg::CfgDataW-1:0] cfg_wdata_i
);

  qva_pkg::cfg_t    cfg;
  qva_pkg::item_t   in_data_q;
  qva_pkg::result_t res;
  qva_pkg::result_t out_data_q;
  logic             in_valid_q, in_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free, fire, in_take;

  qva_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  qva_vote_core #(
    .TimeWidth (TimeWidth)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (in_data_q),
    .fire_i (fire),
    .res_o  (res)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_data_i;
    end
    if (fire) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // rejected or polled items never carry a vote
  a_no_vote_on_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != qva_pkg::StOk) |-> out_data_o.vote_time == '0)
    else $error("vote reported with non-ok status");

  a_host_only_when_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.sync_known |-> out_data_o.sync_host == '0)
    else $error("sync host reported while no sync site known");

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i && in_valid_q)
    else $error("input stalled while result register can move");

  a_fire_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed item lost before result register");

  a_take_fills_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_valid_q)
    else $error("accepted item lost before input register");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for quorum_vote_arbiter: predicts every vote verdict and compares.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 190;

  // Mirror of the voting state; computes the verdict of each accepted item.
  class vote_ledger;
    qva_pkg::cfg_t                  cfg;
    logic [qva_pkg::TimeFieldW-1:0] yes_time, yes_claim, low_time, seen_sync_time;
    logic [qva_pkg::HostWidth-1:0]  yes_host, low_host, seen_sync_host;
    logic                           yes_was_sync;
    qva_pkg::result_t               verdicts_due[$];
    int unsigned                    mismatches;

    function new();
      cfg = '{my_host: qva_pkg::MyHostRst, big_time: qva_pkg::BigTimeRst,
              small_time: qva_pkg::SmallTimeRst, max_skew: qva_pkg::MaxSkewRst};
      mismatches = 0;
      forget('0);
    endfunction

    function void forget(logic [qva_pkg::TimeFieldW-1:0] now);
      yes_time       = now;
      yes_host       = qva_pkg::NoHost;
      yes_claim      = '0;
      yes_was_sync   = 1'b0;
      low_time       = '0;
      low_host       = qva_pkg::NoHost;
      seen_sync_time = '0;
      seen_sync_host = '0;
    endfunction

    // t + d < now, no wrap
    function bit lapsed(logic [qva_pkg::TimeFieldW-1:0] t, logic [qva_pkg::DurWidth-1:0] d,
                        logic [qva_pkg::TimeFieldW-1:0] now);
      return (now > t) && ((now - t) > d);
    endfunction

    function void set_reg(qva_pkg::cfg_reg_e idx, logic [qva_pkg::CfgDataW-1:0] v);
      case (idx)
        qva_pkg::RegMyHost:    cfg.my_host    = v;
        qva_pkg::RegBigTime:   cfg.big_time   = v[qva_pkg::DurWidth-1:0];
        qva_pkg::RegSmallTime: cfg.small_time = v[qva_pkg::DurWidth-1:0];
        qva_pkg::RegMaxSkew:   cfg.max_skew   = v[qva_pkg::DurWidth-1:0];
        default: ;
      endcase
    endfunction

    function qva_pkg::status_e judge(qva_pkg::item_t it,
                                     output logic [qva_pkg::TimeFieldW-1:0] vote);
      logic [qva_pkg::TimeFieldW-1:0] now, start;
      logic [qva_pkg::HostWidth-1:0]  other;
      vote  = '0;
      now   = it.now;
      start = it.claim_start;
      if (it.is_remote && !it.auth_ok) return qva_pkg::StNotAuth;
      if (now > start && (now - start) > cfg.max_skew) return qva_pkg::StSkew;
      if (start > now && (start - now) > cfg.max_skew) begin
        forget(now);
        return qva_pkg::StSkew;
      end
      if (yes_time > now) begin
        forget(now);
        return qva_pkg::StSkew;
      end
      if (yes_time > start && (yes_time - start) > cfg.max_skew) return qva_pkg::StSkew;
      if (it.is_remote && !it.is_member) return qva_pkg::StNotMember;
      other = it.is_remote ? it.other_host : cfg.my_host;

      if (other <= low_host || lapsed(low_time, cfg.big_time, now)) begin
        low_time = now;
        low_host = other;
      end
      if (cfg.my_host <= low_host || lapsed(low_time, cfg.big_time, now)) begin
        low_time = now;
        low_host = cfg.my_host;
      end
      if (it.claims_sync && seen_sync_time <= now) begin
        seen_sync_host = other;
        seen_sync_time = now;
      end
      if (lapsed(seen_sync_time, cfg.big_time, now)) begin
        seen_sync_host = '0;
        seen_sync_time = '0;
      end
      // a plain nominee must agree with the lowest host and any live sync site
      if (!it.claims_sync) begin
        if (low_host != other && !lapsed(low_time, cfg.big_time, now)) return qva_pkg::StOk;
        if (seen_sync_host != '0 && seen_sync_host != other) return qva_pkg::StOk;
      end
      if (yes_claim <= start && (lapsed(yes_time, cfg.big_time, now) || other == yes_host)) begin
        vote         = now;
        yes_time     = now;
        yes_claim    = start;
        yes_host     = other;
        yes_was_sync = it.claims_sync;
      end
      return qva_pkg::StOk;
    endfunction

    function void take_item(qva_pkg::item_t it);
      qva_pkg::result_t               r;
      logic [qva_pkg::TimeFieldW-1:0] vote;
      logic                           known;
      vote     = '0;
      r.status = qva_pkg::StOk;
      if (it.req_type == qva_pkg::ReqBeacon) r.status = judge(it, vote);
      known        = yes_was_sync && !lapsed(yes_claim, cfg.small_time, it.now);
      r.vote_time  = vote;
      r.should_run = lapsed(yes_time, cfg.big_time, it.now) ||
                     !((yes_was_sync && yes_host != cfg.my_host) || yes_host < cfg.my_host);
      r.sync_known = known;
      r.sync_host  = known ? yes_host : '0;
      verdicts_due.push_back(r);
    endfunction

    task flag_mismatch(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_verdict(qva_pkg::result_t got);
      qva_pkg::result_t want;
      if (verdicts_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected item %h", got));
        return;
      end
      want = verdicts_due.pop_front();
      if (got.status !== want.status)
        flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.vote_time !== want.vote_time)
        flag_mismatch($sformatf("vote_time %h, want %h", got.vote_time, want.vote_time));
      if (got.should_run !== want.should_run)
        flag_mismatch($sformatf("should_run %b, want %b", got.should_run, want.should_run));
      if (got.sync_known !== want.sync_known)
        flag_mismatch($sformatf("sync_known %b, want %b", got.sync_known, want.sync_known));
      if (got.sync_host !== want.sync_host)
        flag_mismatch($sformatf("sync_host %h, want %h", got.sync_host, want.sync_host));
    endtask
  endclass

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  qva_pkg::item_t                 in_data   = '0;
  logic                           out_stall = 1'b0;
  logic                           cfg_we    = 1'b0;
  logic [qva_pkg::CfgIdxW-1:0]    cfg_idx   = '0;
  logic [qva_pkg::CfgDataW-1:0]   cfg_wdata = '0;
  logic                           in_stall;
  logic                           out_valid;
  qva_pkg::result_t               out_data;

  vote_ledger                     ledger = new();
  int unsigned                    send_idle_pct = 35;
  int unsigned                    recv_idle_pct = 88;
  int unsigned                    hold_left = 0;
  int unsigned                    cycles = 0;
  logic [qva_pkg::TimeFieldW-1:0] beat = '0;

  quorum_vote_arbiter u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stall, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // outputs are stable from the falling edge up to the accepting edge
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) ledger.check_verdict(out_data);
  end

  task automatic send_item(qva_pkg::item_t it);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    ledger.take_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(qva_pkg::cfg_reg_e idx, logic [qva_pkg::CfgDataW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    ledger.set_reg(idx, v);
  endtask

  task automatic load_config(qva_pkg::cfg_t c);
    put_reg(qva_pkg::RegMyHost, c.my_host);
    put_reg(qva_pkg::RegBigTime, qva_pkg::CfgDataW'(c.big_time));
    put_reg(qva_pkg::RegSmallTime, qva_pkg::CfgDataW'(c.small_time));
    put_reg(qva_pkg::RegMaxSkew, qva_pkg::CfgDataW'(c.max_skew));
    cfg_we <= 1'b0;
  endtask

  function automatic qva_pkg::item_t beacon(logic remote,
                                            logic [qva_pkg::TimeFieldW-1:0] now,
                                            logic [qva_pkg::HostWidth-1:0] host, logic sync,
                                            logic [qva_pkg::TimeFieldW-1:0] start);
    qva_pkg::item_t it;
    it.req_type    = qva_pkg::ReqBeacon;
    it.now         = now;
    it.other_host  = host;
    it.claims_sync = sync;
    it.claim_start = start;
    it.is_remote   = remote;
    it.auth_ok     = 1'b1;
    it.is_member   = 1'b1;
    return it;
  endfunction

  // Mostly coherent beacon streams around a moving clock; some pure noise.
  function automatic qva_pkg::item_t draw_item();
    qva_pkg::item_t it;
    int unsigned    r, off;
    r              = $urandom_range(99);
    it.req_type    = ($urandom_range(9) == 0) ? qva_pkg::ReqPoll : qva_pkg::ReqBeacon;
    it.claims_sync = ($urandom_range(99) < 30);
    it.is_remote   = ($urandom_range(99) < 85);
    it.auth_ok     = ($urandom_range(99) < 94);
    it.is_member   = ($urandom_range(99) < 94);
    if (r < 15) begin
      it.req_type    = 1'($urandom_range(1));
      it.claims_sync = 1'($urandom_range(1));
      it.is_remote   = 1'($urandom_range(1));
      it.auth_ok     = 1'($urandom_range(1));
      it.is_member   = 1'($urandom_range(1));
      it.now         = $urandom;
      it.other_host  = $urandom;
      it.claim_start = $urandom;
      return it;
    end
    if (r < 18) beat = $urandom;
    else if (r < 30) beat += $urandom_range(ledger.cfg.big_time + 2);
    else beat += $urandom_range(2);
    off = ($urandom_range(99) < 8) ? ledger.cfg.max_skew + 1
                                   : $urandom_range(ledger.cfg.max_skew);
    if ($urandom_range(1) && beat <= 32'hffff_ffff - off) it.claim_start = beat + off;
    else if (beat >= off) it.claim_start = beat - off;
    else it.claim_start = beat + off;
    it.now = beat;
    case ($urandom_range(7))
      0:       it.other_host = ledger.cfg.my_host;
      1:       it.other_host = ledger.cfg.my_host + 1;
      2:       it.other_host = ledger.cfg.my_host - 1;
      3:       it.other_host = '0;
      4:       it.other_host = qva_pkg::NoHost;
      7:       it.other_host = $urandom;
      default: it.other_host = $urandom_range(3);
    endcase
    return it;
  endfunction

  initial begin
    qva_pkg::item_t it;
    qva_pkg::cfg_t  plan[6];
    plan[0] = '{my_host: 32'd5, big_time: 16'd75, small_time: 16'd60, max_skew: 16'd10};
    plan[1] = '{my_host: qva_pkg::NoHost, big_time: 16'd0, small_time: 16'd0,
                max_skew: 16'd0};
    plan[2] = '{my_host: 32'd2, big_time: 16'hffff, small_time: 16'hffff,
                max_skew: 16'hffff};
    plan[3] = '{my_host: $urandom, big_time: 16'd20, small_time: 16'd10, max_skew: 16'd3};
    plan[4] = '{my_host: 32'd0, big_time: 16'd1, small_time: 16'hffff, max_skew: 16'd2};
    plan[5] = '{my_host: 32'd3, big_time: 16'd40, small_time: 16'd30, max_skew: 16'd5};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset configuration
    send_item(beacon(1'b1, 32'd0, qva_pkg::NoHost, 1'b1, 32'd0)); // yes vote at time zero
    it = beacon(1'b1, 32'd5, 32'd3, 1'b0, 32'd5);
    it.req_type = qva_pkg::ReqPoll;
    send_item(it);
    it = beacon(1'b1, 32'd20, 32'd3, 1'b0, 32'd20);
    it.auth_ok = 1'b0;
    send_item(it);
    it = beacon(1'b1, 32'd20, 32'd3, 1'b0, 32'd20);
    it.is_member = 1'b0;
    send_item(it);
    it = beacon(1'b0, 32'd30, 32'd9, 1'b0, 32'd30);         // local: flags ignored
    it.auth_ok   = 1'b0;
    it.is_member = 1'b0;
    send_item(it);
    send_item(beacon(1'b1, 32'd100, 32'd3, 1'b0, 32'd89));  // sender behind
    send_item(beacon(1'b1, 32'd100, 32'd3, 1'b0, 32'd111)); // sender ahead, clears
    send_item(beacon(1'b1, 32'd90, 32'd3, 1'b0, 32'd90));   // own vote in future, clears
    send_item(beacon(1'b1, 32'd95, 32'd9, 1'b1, 32'd95));
    send_item(beacon(1'b1, 32'd200, 32'd9, 1'b1, 32'd195)); // vote after timeout
    it = beacon(1'b1, 32'd230, 32'd0, 1'b0, 32'd230);
    it.req_type = qva_pkg::ReqPoll;
    send_item(it);
    send_item(beacon(1'b1, 32'd210, 32'd4, 1'b0, 32'd210)); // refused nominee
    it = beacon(1'b1, 32'd300, 32'd0, 1'b0, 32'd300);
    it.req_type = qva_pkg::ReqPoll;
    send_item(it);
    send_item(beacon(1'b1, 32'hffff_ffff, qva_pkg::NoHost, 1'b1, 32'hffff_ffff));
    send_item(beacon(1'b1, 32'hffff_ffff, qva_pkg::NoHost, 1'b0, 32'hffff_fff5));
    send_item(beacon(1'b1, 32'd0, 32'd0, 1'b0, 32'd0));
    send_item(beacon(1'b0, 32'd0, 32'd0, 1'b0, 32'd0));
    send_item(beacon(1'b1, 32'd76, 32'd0, 1'b0, 32'd76));
    send_item(beacon(1'b1, 32'd77, 32'd1, 1'b1, 32'd67));
    drain();

    for (int p = 0; p < 6; p++) begin
      load_config(plan[p]);
      @(posedge clk);
      case (p / 2)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (p == 2 || p == 4) begin
        // long hold-off so the block backs up into its input
        @(negedge clk);
        hold_left = 150;
        @(posedge clk);
      end
      for (int n = 0; n < PhaseItems; n++) send_item(draw_item());
      drain();
    end

    repeat (8) @(posedge clk);
    if (ledger.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/qva_pkg.sv
hw/rtl/qva_cfg_regs.sv
hw/rtl/qva_vote_core.sv
hw/rtl/quorum_vote_arbiter.sv
sim/tb_top.sv
